FILE: hdl/hbs_pkg.sv
// ---------------------------------------------------------------------------
// hbs_pkg
// Types, codes and fixed field widths shared by the heightfield sampler.
// ---------------------------------------------------------------------------
package hbs_pkg;

    localparam int POS_W     = 14;
    localparam int HEIGHT_W  = 16;
    localparam int DIM_REG_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // command field
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEVEL  = 2'd2;

    // corner select: bit 0 is the x offset, bit 1 the z offset
    localparam logic [1:0] CORNER_00 = 2'd0;
    localparam logic [1:0] CORNER_10 = 2'd1;
    localparam logic [1:0] CORNER_01 = 2'd2;
    localparam logic [1:0] CORNER_11 = 2'd3;

    // lerp operand select
    localparam logic [1:0] LERP_TOP = 2'd0;
    localparam logic [1:0] LERP_BOT = 2'd1;
    localparam logic [1:0] LERP_Z   = 2'd2;

    typedef struct packed {
        logic                       cmd;
        logic [POS_W-1:0]           pos_x;
        logic [POS_W-1:0]           pos_z;
        logic signed [HEIGHT_W-1:0] new_height;
    } req_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height;
        logic                       in_range;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic       clr;
        logic       load_req;
        logic       mem_wr;
        logic [1:0] corner;
        logic       cap_en;
        logic [1:0] cap_corner;
        logic       mul_en;
        logic       acc_en;
        logic [1:0] lerp_sel;
        logic       rsp_hit;
        logic       rsp_miss;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic is_read;
        logic wr_ok;
        logic rd_ok;
        logic rsp_free;
    } stat_t;

endpackage

FILE: hdl/heightfield_bilinear_sampler.sv
// A write is accepted, then stored; a read, from accept to response valid,
//   runs four reads through the single memory port and three lerps sharing
//   one multiply/add unit. An out-of-range read goes from decode to a miss.
// Throughput: one item at a time; next item accepted the cycle after finish,
//   even while the previous response is still stalled in the output register.
// Reset: async, active low; a sweep over all GRID_DIM*GRID_DIM cells then
//   clears the written flags, with input stalled and config writes still taken.
// ---------------------------------------------------------------------------
// heightfield_bilinear_sampler
// Height grid with per-cell write and bilinear fixed-point read.
// ---------------------------------------------------------------------------
module heightfield_bilinear_sampler #(
    parameter int GRID_DIM  = 64,     // store is GRID_DIM x GRID_DIM cells
    parameter int FRAC_BITS = 8       // fractional bits of pos_x / pos_z
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request item channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  hbs_pkg::req_t                 req,
    // response item channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output hbs_pkg::rsp_t                 rsp,
    // config write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hbs_pkg::CFG_DAT_W-1:0] cfg_data
);
    import hbs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // config registers never block
    assign cfg_ready = 1'b1;

    // Controller: clear sweep after reset, then per item:
    //   decode -> (write | miss | 4 corner reads -> top lerp -> bottom lerp
    //   -> z lerp) -> load response register when it is free.
    hbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: memory word is {written, height}; unwritten cells read as
    // base_level. Lerp rounds to nearest, ties up, via floor of (d*f + half).
    hbs_datapath #(
        .GRID_DIM  (GRID_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

FILE: hdl/hbs_ctrl.sv
// ---------------------------------------------------------------------------
// hbs_ctrl
// Sequencer: clear sweep, write, out-of-range miss, four corner reads, three shared lerps.
// ---------------------------------------------------------------------------
module hbs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  hbs_pkg::stat_t stat,
    output hbs_pkg::cmd_t  cmd
);
    import hbs_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_RD00   = 4'd3;
    localparam logic [3:0] S_RD10   = 4'd4;
    localparam logic [3:0] S_RD01   = 4'd5;
    localparam logic [3:0] S_RD11   = 4'd6;
    localparam logic [3:0] S_LX     = 4'd7;
    localparam logic [3:0] S_MULB   = 4'd8;
    localparam logic [3:0] S_ACCB   = 4'd9;
    localparam logic [3:0] S_MULZ   = 4'd10;
    localparam logic [3:0] S_ACCZ   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;
    localparam logic [3:0] S_MISS   = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.corner = CORNER_00;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!stat.is_read)
                begin
                    cmd.mem_wr = stat.wr_ok;
                    state_next = S_IDLE;
                end
                else if (stat.rd_ok)
                begin
                    state_next = S_RD00;
                end
                else
                begin
                    state_next = S_MISS;
                end
            end
            S_RD00:
            begin
                cmd.corner = CORNER_00;
                state_next = S_RD10;
            end
            S_RD10:
            begin
                cmd.corner     = CORNER_10;
                cmd.cap_en     = 1'b1;
                cmd.cap_corner = CORNER_00;
                state_next     = S_RD01;
            end
            S_RD01:
            begin
                cmd.corner     = CORNER_01;
                cmd.cap_en     = 1'b1;
                cmd.cap_corner = CORNER_10;
                state_next     = S_RD11;
            end
            S_RD11:
            begin
                cmd.corner     = CORNER_11;
                cmd.cap_en     = 1'b1;
                cmd.cap_corner = CORNER_01;
                cmd.mul_en     = 1'b1;
                cmd.lerp_sel   = LERP_TOP;
                state_next     = S_LX;
            end
            S_LX:
            begin
                cmd.cap_en     = 1'b1;
                cmd.cap_corner = CORNER_11;
                cmd.acc_en     = 1'b1;
                cmd.lerp_sel   = LERP_TOP;
                state_next     = S_MULB;
            end
            S_MULB:
            begin
                cmd.mul_en   = 1'b1;
                cmd.lerp_sel = LERP_BOT;
                state_next   = S_ACCB;
            end
            S_ACCB:
            begin
                cmd.acc_en   = 1'b1;
                cmd.lerp_sel = LERP_BOT;
                state_next   = S_MULZ;
            end
            S_MULZ:
            begin
                cmd.mul_en   = 1'b1;
                cmd.lerp_sel = LERP_Z;
                state_next   = S_ACCZ;
            end
            S_ACCZ:
            begin
                cmd.acc_en   = 1'b1;
                cmd.lerp_sel = LERP_Z;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (stat.rsp_free)
                begin
                    cmd.rsp_hit = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_MISS:
            begin
                if (stat.rsp_free)
                begin
                    cmd.rsp_miss = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/hbs_datapath.sv
// ---------------------------------------------------------------------------
// hbs_datapath
// Config registers, height memory with written flag, corner registers,
// shared lerp unit (multiply stage, then add stage) and response register.
// ---------------------------------------------------------------------------
module hbs_datapath #(
    parameter int GRID_DIM  = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hbs_pkg::req_t                     req,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hbs_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  hbs_pkg::cmd_t                     cmd,
    output hbs_pkg::stat_t                    stat,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output hbs_pkg::rsp_t                     rsp
);
    import hbs_pkg::*;

    localparam int CELLS  = GRID_DIM * GRID_DIM;
    localparam int AW     = $clog2(CELLS);
    localparam int IW     = POS_W - FRAC_BITS;
    localparam int CW     = 11;                 // holds integer part + 1 and dims
    localparam int FULL_W = IW + 11;            // z * GRID_DIM + x before truncation
    localparam int PW     = HEIGHT_W + FRAC_BITS + 3;
    localparam int WORD_W = HEIGHT_W + 1;       // {written, height}
    localparam logic [8:0] DIM9 = 9'(GRID_DIM);
    localparam logic signed [PW-1:0] HALF = PW'(2 ** (FRAC_BITS - 1));

    // config registers
    logic [DIM_REG_W-1:0]       grid_width_reg;
    logic [DIM_REG_W-1:0]       grid_length_reg;
    logic signed [HEIGHT_W-1:0] base_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= DIM_REG_W'(64);
            grid_length_reg <= DIM_REG_W'(64);
            base_level_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[DIM_REG_W-1:0];
                CFG_GRID_LENGTH: grid_length_reg <= cfg_data[DIM_REG_W-1:0];
                CFG_BASE_LEVEL:  base_level_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // request register
    req_t req_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
    end

    // effective dims clamp at GRID_DIM
    logic [8:0]          dim_w;
    logic [8:0]          dim_l;
    logic [CW-1:0]       w_c;
    logic [CW-1:0]       l_c;
    logic [IW-1:0]       ix;
    logic [IW-1:0]       iz;
    logic [CW-1:0]       ix_c;
    logic [CW-1:0]       iz_c;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fz;

    always_comb
    begin
        dim_w = {2'b00, grid_width_reg};
        dim_l = {2'b00, grid_length_reg};
        if (dim_w > DIM9)
        begin
            dim_w = DIM9;
        end
        if (dim_l > DIM9)
        begin
            dim_l = DIM9;
        end
    end

    assign w_c  = CW'(dim_w);
    assign l_c  = CW'(dim_l);
    assign ix   = req_reg.pos_x[POS_W-1:FRAC_BITS];
    assign iz   = req_reg.pos_z[POS_W-1:FRAC_BITS];
    assign ix_c = CW'(ix);
    assign iz_c = CW'(iz);
    assign fx   = req_reg.pos_x[FRAC_BITS-1:0];
    assign fz   = req_reg.pos_z[FRAC_BITS-1:0];

    // clear sweep counter
    logic [AW-1:0] clr_cnt_reg;
    logic          clr_last;

    assign clr_last = (clr_cnt_reg == AW'(CELLS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr)
        begin
            clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + AW'(1);
        end
    end

    assign stat.clr_last = clr_last;
    assign stat.is_read  = (req_reg.cmd == CMD_READ);
    assign stat.wr_ok    = (ix_c < w_c) && (iz_c < l_c);
    assign stat.rd_ok    = (ix_c + CW'(1) < w_c) && (iz_c + CW'(1) < l_c);

    // corner address: z * GRID_DIM + x
    logic [IW:0]       xs;
    logic [IW:0]       zs;
    logic [FULL_W-1:0] addr_full;
    logic [AW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_we;

    assign xs        = {1'b0, ix} + (IW + 1)'(cmd.corner[0]);
    assign zs        = {1'b0, iz} + (IW + 1)'(cmd.corner[1]);
    assign addr_full = FULL_W'(zs) * FULL_W'(GRID_DIM) + FULL_W'(xs);
    assign mem_addr  = cmd.clr ? clr_cnt_reg : addr_full[AW-1:0];
    assign mem_we    = cmd.clr || cmd.mem_wr;
    assign mem_wdata = cmd.clr ? '0 : {1'b1, req_reg.new_height};

    // single-port height memory, registered read
    logic [WORD_W-1:0] mem [CELLS];
    logic [WORD_W-1:0] mem_q_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_q_reg <= mem[mem_addr];
    end

    logic signed [HEIGHT_W-1:0] fetched;

    assign fetched = mem_q_reg[WORD_W-1] ? mem_q_reg[HEIGHT_W-1:0] : base_level_reg;

    // corner registers
    logic signed [HEIGHT_W-1:0] c00_reg;
    logic signed [HEIGHT_W-1:0] c10_reg;
    logic signed [HEIGHT_W-1:0] c01_reg;
    logic signed [HEIGHT_W-1:0] c11_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
        begin
            case (cmd.cap_corner)
                CORNER_00: c00_reg <= fetched;
                CORNER_10: c10_reg <= fetched;
                CORNER_01: c01_reg <= fetched;
                default:   c11_reg <= fetched;
            endcase
        end
    end

    // shared lerp: a + floor(((b - a) * f + half) / 2^FRAC_BITS)
    logic signed [HEIGHT_W-1:0] top_reg;
    logic signed [HEIGHT_W-1:0] bot_reg;
    logic signed [HEIGHT_W-1:0] h_reg;
    logic signed [HEIGHT_W-1:0] a_op;
    logic signed [HEIGHT_W-1:0] b_op;
    logic [FRAC_BITS-1:0]       f_op;
    logic signed [HEIGHT_W:0]   diff;
    logic signed [PW-1:0]       diff_x;
    logic signed [PW-1:0]       f_x;
    logic signed [PW-1:0]       prod_next;
    logic signed [PW-1:0]       prod_reg;
    logic signed [PW-1:0]       shifted;
    logic [HEIGHT_W:0]          sum;
    logic signed [HEIGHT_W-1:0] lerp_res;

    always_comb
    begin
        case (cmd.lerp_sel)
            LERP_TOP:
            begin
                a_op = c00_reg;
                b_op = c10_reg;
                f_op = fx;
            end
            LERP_BOT:
            begin
                a_op = c01_reg;
                b_op = c11_reg;
                f_op = fx;
            end
            LERP_Z:
            begin
                a_op = top_reg;
                b_op = bot_reg;
                f_op = fz;
            end
            default:
            begin
                a_op = top_reg;
                b_op = bot_reg;
                f_op = fz;
            end
        endcase
    end

    assign diff      = (HEIGHT_W + 1)'(b_op) - (HEIGHT_W + 1)'(a_op);
    assign diff_x    = PW'(diff);
    assign f_x       = PW'({1'b0, f_op});
    assign prod_next = diff_x * f_x + HALF;
    assign shifted   = prod_reg >>> FRAC_BITS;
    assign sum       = (HEIGHT_W + 1)'(a_op) + shifted[HEIGHT_W:0];
    assign lerp_res  = sum[HEIGHT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.acc_en)
        begin
            case (cmd.lerp_sel)
                LERP_TOP: top_reg <= lerp_res;
                LERP_BOT: bot_reg <= lerp_res;
                default:  h_reg   <= lerp_res;
            endcase
        end
    end

    // response register
    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_reg;

    assign stat.rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.rsp_hit || cmd.rsp_miss)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rsp_hit)
        begin
            rsp_reg.height   <= h_reg;
            rsp_reg.in_range <= 1'b1;
        end
        else if (cmd.rsp_miss)
        begin
            rsp_reg.height   <= '0;
            rsp_reg.in_range <= 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: hdl/hbs_checker.sv
// ---------------------------------------------------------------------------
// hbs_checker
// Port-level checks for the heightfield sampler, bound to the top level.
// ---------------------------------------------------------------------------
module hbs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input hbs_pkg::rsp_t rsp
);
    import hbs_pkg::*;

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // out-of-range response carries zero height
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.in_range |-> rsp.height == '0)
        else $error("out-of-range response with nonzero height");

    // one item in flight: an accept is followed by a stalled cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second item accepted back to back");

    // a new response only appears after the block was busy
    a_rsp_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response raised without work in progress");

endmodule

bind heightfield_bilinear_sampler hbs_checker u_hbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

FILE: bench/hbs_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hbs_check
// Watches the request, response and config channels of the height sampler,
// keeps its own copy of the grid and registers, and compares each response
// item with the oldest predicted one.
// ---------------------------------------------------------------------------
module hbs_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  hbs_pkg::req_t                 req,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  hbs_pkg::rsp_t                 rsp,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [hbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hbs_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                            errors,
    output int                            pending
);
    import hbs_pkg::*;

    localparam int DIM  = 64;
    localparam int FRAC = 8;

    logic signed [HEIGHT_W-1:0] grid_height [DIM*DIM];
    bit                         grid_set    [DIM*DIM];
    logic [DIM_REG_W-1:0]       width_reg;
    logic [DIM_REG_W-1:0]       length_reg;
    logic signed [HEIGHT_W-1:0] base_reg;
    rsp_t                       height_due [$];
    int                         fail_total;

    function automatic int dim_cap(input logic [DIM_REG_W-1:0] d);
        return (d > DIM) ? DIM : int'(d);
    endfunction

    // unwritten cells follow the current base level
    function automatic int corner_height(input int x, input int z);
        int a;
        a = z * DIM + x;
        return grid_set[a] ? int'(grid_height[a]) : int'(base_reg);
    endfunction

    // a + (b - a) * f / 2^FRAC, rounded half up (floor after adding half)
    function automatic int lerp_q(input int a, input int b, input int f);
        longint p;
        p = longint'(b - a) * longint'(f) + longint'(1 << (FRAC - 1));
        return a + int'(p >>> FRAC);
    endfunction

    function automatic rsp_t sample_height(input req_t item);
        rsp_t r;
        int   ix, iz, fx, fz, top_row, bot_row;
        ix = int'(item.pos_x >> FRAC);
        iz = int'(item.pos_z >> FRAC);
        fx = int'(item.pos_x[FRAC-1:0]);
        fz = int'(item.pos_z[FRAC-1:0]);
        r  = '0;
        if (ix + 1 < dim_cap(width_reg) && iz + 1 < dim_cap(length_reg))
        begin
            top_row    = lerp_q(corner_height(ix, iz), corner_height(ix + 1, iz), fx);
            bot_row    = lerp_q(corner_height(ix, iz + 1),
                                corner_height(ix + 1, iz + 1), fx);
            r.height   = HEIGHT_W'(lerp_q(top_row, bot_row, fz));
            r.in_range = 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        int   ix, iz;
        if (!rst_n)
        begin
            foreach (grid_set[i])
                grid_set[i] = 1'b0;
            width_reg  = 7'd64;
            length_reg = 7'd64;
            base_reg   = '0;
            height_due.delete();
            fail_total = 0;
            errors     <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GRID_WIDTH:  width_reg  = cfg_data[DIM_REG_W-1:0];
                    CFG_GRID_LENGTH: length_reg = cfg_data[DIM_REG_W-1:0];
                    CFG_BASE_LEVEL:  base_reg   = cfg_data;
                    default: ;
                endcase
            end

            if (rsp_valid && !rsp_stall)
            begin
                if (height_due.size() == 0)
                begin
                    $display("%0t: response item with none pending: height %0d in_range %0b",
                             $time, rsp.height, rsp.in_range);
                    fail_total++;
                end
                else
                begin
                    want = height_due.pop_front();
                    if (rsp.height !== want.height)
                    begin
                        $display("%0t: height expected %0d, actual %0d",
                                 $time, want.height, rsp.height);
                        fail_total++;
                    end
                    if (rsp.in_range !== want.in_range)
                    begin
                        $display("%0t: in_range expected %0b, actual %0b",
                                 $time, want.in_range, rsp.in_range);
                        fail_total++;
                    end
                end
            end

            if (req_valid && !req_stall)
            begin
                if (req.cmd == CMD_READ)
                    height_due.push_back(sample_height(req));
                else
                begin
                    ix = int'(req.pos_x >> FRAC);
                    iz = int'(req.pos_z >> FRAC);
                    if (ix < dim_cap(width_reg) && iz < dim_cap(length_reg))
                    begin
                        grid_height[iz * DIM + ix] = req.new_height;
                        grid_set[iz * DIM + ix]    = 1'b1;
                    end
                end
            end

            errors  <= fail_total;
            pending <= height_due.size();
        end
    end

endmodule

FILE: bench/heightfield_bilinear_sampler_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heightfield_bilinear_sampler_test
// Drives write and read items into the height sampler under random gaps and
// output stalls, across several grid sizes and base levels; hbs_check
// predicts and compares every response item.
// ---------------------------------------------------------------------------
module heightfield_bilinear_sampler_test;
    import hbs_pkg::*;

    // index with no register behind it; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int PHASES    = 9;
    localparam int PHASE_LEN = 150;
    // phase run with no gaps and no stalls at all
    localparam int QUIET_PHASE = 3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_t                 req       = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    int errors;
    int pending;

    // chance, in percent, that a side idles in a given cycle
    int idle_pct  = 29;
    int stall_pct = 29;

    // grid settings per phase; the extremes 0, 1, 2, 64 and 127 all appear,
    // 127 standing in for any oversized value
    int unsigned                ph_width  [PHASES] = '{64, 2, 127, 9, 0, 17, 64, 33, 1};
    int unsigned                ph_length [PHASES] = '{64, 2, 5, 64, 13, 1, 2, 47, 127};
    logic signed [HEIGHT_W-1:0] ph_base   [PHASES] = '{16'sh8000, 16'sh7FFF, 16'sh0A5C,
                                                       16'sh0000, -16'sd1, 16'sd100,
                                                       16'shC3E1, 16'sh2468, 16'sh9B7D};

    always #5 clk = ~clk;

    heightfield_bilinear_sampler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hbs_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // receiver back-pressure, one fresh decision per cycle
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    // Hand one item over. An optional gap drops valid first; otherwise valid
    // stays high from the previous item and only the payload moves on.
    task automatic send_item(input req_t item);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Drop valid and wait until every predicted response has come back, then
    // give a trailing write (no response of its own) time to land.
    task automatic drain;
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);
    endtask

    // Back-to-back register writes with valid held high between them. Upper
    // data bits of the size registers carry junk, which the block must mask.
    task automatic program_grid(input int unsigned w, input int unsigned l,
                                input logic signed [HEIGHT_W-1:0] base,
                                input bit poke_unused);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_DAT_W-1:0] dat [4];
        int                   n;
        idx[0] = CFG_GRID_WIDTH;
        dat[0] = {9'($urandom), 7'(w)};
        idx[1] = CFG_GRID_LENGTH;
        dat[1] = {9'($urandom), 7'(l)};
        idx[2] = CFG_BASE_LEVEL;
        dat[2] = base;
        idx[3] = CFG_UNUSED;
        dat[3] = 16'($urandom);
        n = poke_unused ? 4 : 3;
        for (int i = 0; i < n; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= dat[i];
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic req_t pack_req(input logic cmd, input logic [POS_W-1:0] x,
                                      input logic [POS_W-1:0] z,
                                      input logic [HEIGHT_W-1:0] h);
        req_t item;
        item.cmd        = cmd;
        item.pos_x      = x;
        item.pos_z      = z;
        item.new_height = h;
        return item;
    endfunction

    // fraction with extra weight on the end points
    function automatic logic [7:0] pick_frac;
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Random item biased toward the live grid, and mostly toward its low
    // corner, so reads land on cells written earlier in the run.
    function automatic req_t make_probe(input int w, input int l);
        req_t item;
        int   xhi, zhi, ix, iz;
        xhi = ($urandom_range(99) < 60 && w > 8) ? 8 : w;
        zhi = ($urandom_range(99) < 60 && l > 8) ? 8 : l;
        ix  = (xhi > 0 && $urandom_range(99) < 85) ? $urandom_range(xhi - 1)
                                                   : $urandom_range(63);
        iz  = (zhi > 0 && $urandom_range(99) < 85) ? $urandom_range(zhi - 1)
                                                   : $urandom_range(63);
        item.cmd   = ($urandom_range(99) < 55) ? CMD_READ : CMD_WRITE;
        item.pos_x = {6'(ix), pick_frac()};
        item.pos_z = {6'(iz), pick_frac()};
        case ($urandom_range(9))
            0:       item.new_height = 16'sh7FFF;
            1:       item.new_height = 16'sh8000;
            default: item.new_height = 16'($urandom);
        endcase
        return item;
    endfunction

    initial
    begin
        int w_eff;
        int l_eff;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Registers at their reset values, written once anyway; the unused
        // index gets a write too. The block is still clearing its written
        // flags here, so the first items wait on req_stall.
        program_grid(64, 64, 16'sh0000, 1'b1);

        // --- directed part on the full 64 x 64 grid, base level zero ---
        // unwritten cell reads as the base level
        send_item(pack_req(CMD_READ,  14'h0000, 14'h0000, 16'h0000));
        // extreme heights on the four corners of cell (0,0)
        send_item(pack_req(CMD_WRITE, 14'h0000, 14'h0000, 16'h7FFF));
        send_item(pack_req(CMD_WRITE, 14'h0100, 14'h0000, 16'h8000));
        send_item(pack_req(CMD_WRITE, 14'h0000, 14'h0100, 16'h8000));
        // fraction bits of a write are dropped: this lands on cell (1,1)
        send_item(pack_req(CMD_WRITE, 14'h01FF, 14'h01FF, 16'h7FFF));
        send_item(pack_req(CMD_READ,  14'h0000, 14'h0000, 16'hFFFF));
        send_item(pack_req(CMD_READ,  14'h00FF, 14'h0000, 16'h0000));
        send_item(pack_req(CMD_READ,  14'h0080, 14'h0080, 16'h0000));
        send_item(pack_req(CMD_READ,  14'h00FF, 14'h00FF, 16'h0000));
        send_item(pack_req(CMD_READ,  14'h0001, 14'h00FF, 16'h0000));
        // far corner of the store, and the cell next to it
        send_item(pack_req(CMD_WRITE, 14'h3FFF, 14'h3FFF, 16'h1234));
        send_item(pack_req(CMD_WRITE, 14'h3E00, 14'h3F00, 16'hFFFF));
        send_item(pack_req(CMD_READ,  14'h3EFF, 14'h3EFF, 16'h0000));
        // last column, last row and the top of the position range are out
        send_item(pack_req(CMD_READ,  14'h3F00, 14'h0000, 16'h0000));
        send_item(pack_req(CMD_READ,  14'h0000, 14'h3F80, 16'h0000));
        send_item(pack_req(CMD_READ,  14'h3FFF, 14'h3FFF, 16'h0000));
        // mixed bit patterns in the middle of the grid
        send_item(pack_req(CMD_READ,  14'h2A55, 14'h15AA, 16'h0000));
        send_item(pack_req(CMD_WRITE, 14'h2AAA, 14'h1555, 16'h5555));
        send_item(pack_req(CMD_READ,  14'h2A80, 14'h1480, 16'h0000));
        send_item(pack_req(CMD_READ,  14'h29C0, 14'h1540, 16'h0000));

        // --- random part, one grid setting per phase ---
        // The store is kept across phases, so each setting also sees cells
        // written under earlier sizes and base levels. Tiny sizes make every
        // read miss; small sizes put many writes outside the grid.
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            program_grid(ph_width[p], ph_length[p], ph_base[p], p == 5);
            idle_pct  = (p == QUIET_PHASE) ? 0 : 29;
            stall_pct = (p == QUIET_PHASE) ? 0 : 29;
            w_eff = (ph_width[p] > 64) ? 64 : int'(ph_width[p]);
            l_eff = (ph_length[p] > 64) ? 64 : int'(ph_length[p]);
            for (int i = 0; i < PHASE_LEN; i++)
                send_item(make_probe(w_eff, l_eff));
        end

        drain();
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // hard stop; a correct run ends far earlier
    initial
    begin
        #(5_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
